### hdl/gtli_pkg.sv
// shared types, constants and control/status structs of the grid table interpolator
package gtli_pkg;

  // field widths
  localparam int GRID_POINTS = 16;
  localparam int PT_W        = 4;
  localparam int SITE_W      = 4;
  localparam int CLS_W       = 2;
  localparam int FAM_W       = 2;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 5;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int TAB_AW      = SITE_W + PT_W + CLS_W + FAM_W;
  localparam int TAB_DEPTH   = 1 << TAB_AW;

  localparam logic [CNT_W-1:0]  PTS_RESET = CNT_W'(GRID_POINTS);
  localparam logic [DATA_W-1:0] ONE_Q16   = 32'h0001_0000;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_BP  = 2'd0,
    OP_WR_TAB = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    STS_OK      = 2'd0,
    STS_BELOW   = 2'd1,
    STS_OUTSIDE = 2'd2
  } sts_code_t;

  // selection for the pending result register
  typedef enum logic [2:0] {
    PEND_HOLD,
    PEND_ZERO,
    PEND_BELOW,
    PEND_OUTSIDE,
    PEND_CALC
  } pend_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RD_LO,
    S_RD_HI,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  accept;
    logic  bp_wr;
    logic  tab_wr;
    logic  scan_adv;
    logic  hit;
    logic  rd_lo;
    logic  rd_hi;
    logic  diff;
    logic  mul;
    logic  div_step;
    logic  out_load;
    pend_t pend;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic first;
    logic below;
    logic at_end;
    logic hit;
    logic div_last;
  } sts_t;

endpackage

### hdl/grid_table_linear_interpolator.sv
// top level of the grid table linear interpolator
// Holds a 16-point ascending breakpoint grid and a 16x16x4x4 table of Q16.16
// values, loaded by write items (operation 0 breakpoint, 1 table value), and
// answers interpolate items (operation 2) with the linearly interpolated table
// value at x, 0 with status below-grid if x lies under the first breakpoint,
// or 1.0 with status outside-grid if no segment holds x. One item is worked
// at a time. A write or no-op item passes through the pending result
// register to the output register. A query searches for its segment or
// leaves the grid, one breakpoint per cycle; below-grid and outside-grid
// answers then pass through the pending result register to the output
// register. An interpolating query instead reads the two table values,
// forms their difference, multiplies, runs the one-bit-per-cycle divider
// and finishes into the pending result register. The next item enters the
// cycle after a result is handed to the output register, and the output
// register lets it enter while a result waits. points_in_use is to be
// written through cfg_we/cfg_data only while the block is idle, which the
// block itself does not enforce; reset sets it to 16.
module grid_table_linear_interpolator
  import gtli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [SITE_W-1:0] in_site,
  input  logic [CLS_W-1:0]  in_class_index,
  input  logic [FAM_W-1:0]  in_family,
  input  logic [PT_W-1:0]   in_grid_point,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_result,
  output logic [ST_W-1:0]   out_status
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  gtli_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // storage and arithmetic
  gtli_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_site        (in_site),
    .in_class_index (in_class_index),
    .in_family      (in_family),
    .in_grid_point  (in_grid_point),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_result     (out_result),
    .out_status     (out_status)
  );

endmodule

### hdl/gtli_ctrl.sv
// controller state machine of the grid table interpolator
module gtli_ctrl
  import gtli_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_operation,
  output logic            out_valid,
  input  logic            out_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;
  op_t    op;

  assign op        = op_t'(in_operation);
  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.pend      = PEND_HOLD;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          case (op)
            OP_WR_BP: begin
              cmd.bp_wr = 1'b1;
              cmd.pend  = PEND_ZERO;
              state_nxt = S_OUT;
            end
            OP_WR_TAB: begin
              cmd.tab_wr = 1'b1;
              cmd.pend   = PEND_ZERO;
              state_nxt  = S_OUT;
            end
            OP_QUERY: begin
              state_nxt = S_SCAN;
            end
            default: begin
              cmd.pend  = PEND_ZERO;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      // one breakpoint per cycle
      S_SCAN: begin
        if (sts.first) begin
          if (sts.below) begin
            cmd.pend  = PEND_BELOW;
            state_nxt = S_OUT;
          end else begin
            cmd.scan_adv = 1'b1;
          end
        end else if (sts.at_end) begin
          cmd.pend  = PEND_OUTSIDE;
          state_nxt = S_OUT;
        end else if (sts.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_RD_LO;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      // one quotient bit per cycle
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.pend  = PEND_CALC;
        state_nxt = S_OUT;
      end
      // hand the pending result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/gtli_dp.sv
// datapath of the grid table interpolator: stores, scan, multiplier, serial divider
module gtli_dp
  import gtli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic [SITE_W-1:0] in_site,
  input  logic [CLS_W-1:0]  in_class_index,
  input  logic [FAM_W-1:0]  in_family,
  input  logic [PT_W-1:0]   in_grid_point,
  input  logic [DATA_W-1:0] in_value,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [DATA_W-1:0] out_result,
  output logic [ST_W-1:0]   out_status
);

  logic [CNT_W-1:0]  pts_r;
  logic [DATA_W-1:0] bp_r [GRID_POINTS];
  logic [DATA_W-1:0] tab_mem [TAB_DEPTH];
  logic [DATA_W-1:0] rd_r;

  logic [SITE_W-1:0] site_r;
  logic [CLS_W-1:0]  cls_r;
  logic [FAM_W-1:0]  fam_r;
  logic [DATA_W-1:0] x_r;
  logic [CNT_W-1:0]  idx_r;
  logic [DATA_W-1:0] prev_r;
  logic [DATA_W-1:0] w1_r;
  logic [PT_W-1:0]   l_r;
  logic [DATA_W-1:0] dx_r;
  logic [DATA_W-1:0] dw_r;
  logic [DATA_W-1:0] y1_r;
  logic              neg_r;
  logic [DATA_W-1:0] mag_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [CNT_W-1:0]  div_cnt_r;
  logic [DATA_W-1:0] pend_res_r;
  logic [ST_W-1:0]   pend_st_r;
  logic [DATA_W-1:0] out_res_r;
  logic [ST_W-1:0]   out_st_r;

  logic [CNT_W-1:0]    pts_cap;
  logic [DATA_W-1:0]   bp_cur;
  logic [PT_W-1:0]     rd_pt;
  logic [TAB_AW-1:0]   tab_addr;
  logic [DATA_W:0]     dy;
  logic [DATA_W:0]     dy_abs;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]     div_sh;
  logic                div_ge;
  logic [DATA_W:0]     div_sub;
  logic [DATA_W+1:0]   sum;
  logic [DATA_W-1:0]   sat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= PTS_RESET;
    end else if (cfg_we) begin
      pts_r <= cfg_data;
    end
  end

  assign pts_cap = (pts_r > CNT_W'(GRID_POINTS)) ? CNT_W'(GRID_POINTS) : pts_r;

  // breakpoint store, read at the scan index only
  always_ff @(posedge clk) begin
    if (cmd.bp_wr) begin
      bp_r[in_grid_point] <= in_value;
    end
  end

  assign bp_cur = bp_r[idx_r[PT_W-1:0]];

  // value table, one port, registered read
  assign rd_pt    = cmd.rd_lo ? (l_r - PT_W'(1)) : l_r;
  assign tab_addr = cmd.tab_wr ? {in_site, in_grid_point, in_class_index, in_family}
                               : {site_r, rd_pt, cls_r, fam_r};

  always_ff @(posedge clk) begin
    if (cmd.tab_wr) begin
      tab_mem[tab_addr] <= in_value;
    end
    rd_r <= tab_mem[tab_addr];
  end

  // scan status
  assign sts.first    = (idx_r == '0);
  assign sts.below    = $signed(x_r) < $signed(bp_cur);
  assign sts.at_end   = (idx_r >= pts_cap);
  assign sts.hit      = ($signed(prev_r) <= $signed(x_r)) && ($signed(x_r) < $signed(bp_cur));
  assign sts.div_last = (div_cnt_r == CNT_W'(DATA_W - 1));

  // query latch and segment scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      site_r <= in_site;
      cls_r  <= in_class_index;
      fam_r  <= in_family;
      x_r    <= in_value;
      idx_r  <= '0;
    end
    if (cmd.scan_adv) begin
      prev_r <= bp_cur;
      idx_r  <= idx_r + CNT_W'(1);
    end
    if (cmd.hit) begin
      l_r  <= idx_r[PT_W-1:0];
      w1_r <= bp_cur;
    end
  end

  // segment offsets
  always_ff @(posedge clk) begin
    if (cmd.rd_lo) begin
      dx_r <= x_r - prev_r;
    end
    if (cmd.rd_hi) begin
      dw_r <= w1_r - prev_r;
      y1_r <= rd_r;
    end
  end

  // value difference, sign and magnitude
  assign dy     = {rd_r[DATA_W-1], rd_r} - {y1_r[DATA_W-1], y1_r};
  assign dy_abs = dy[DATA_W] ? (~dy + (DATA_W+1)'(1)) : dy;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      neg_r <= dy[DATA_W];
      mag_r <= dy_abs[DATA_W-1:0];
    end
  end

  // product, then restoring division; high half stays below the divisor
  assign prod    = mag_r * dx_r;
  assign div_sh  = {rem_r, quo_r[DATA_W-1]};
  assign div_ge  = div_sh >= {1'b0, dw_r};
  assign div_sub = div_sh - {1'b0, dw_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r     <= prod[2*DATA_W-1:DATA_W];
      quo_r     <= prod[DATA_W-1:0];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= div_ge ? div_sub[DATA_W-1:0] : div_sh[DATA_W-1:0];
      quo_r     <= {quo_r[DATA_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
  end

  // final sum with saturation
  assign sum = neg_r ? ({{2{y1_r[DATA_W-1]}}, y1_r} - {2'b00, quo_r})
                     : ({{2{y1_r[DATA_W-1]}}, y1_r} + {2'b00, quo_r});

  always_comb begin
    if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
      sat = sum[DATA_W-1:0];
    end else if (sum[DATA_W+1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    case (cmd.pend)
      PEND_ZERO: begin
        pend_res_r <= '0;
        pend_st_r  <= STS_OK;
      end
      PEND_BELOW: begin
        pend_res_r <= '0;
        pend_st_r  <= STS_BELOW;
      end
      PEND_OUTSIDE: begin
        pend_res_r <= ONE_Q16;
        pend_st_r  <= STS_OUTSIDE;
      end
      PEND_CALC: begin
        pend_res_r <= sat;
        pend_st_r  <= STS_OK;
      end
      default: begin
        pend_res_r <= pend_res_r;
        pend_st_r  <= pend_st_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= pend_res_r;
      out_st_r  <= pend_st_r;
    end
  end

  assign out_result = out_res_r;
  assign out_status = out_st_r;

endmodule
